### hdl/gyro_bias_calibrated_integrator_unit_macros.svh
// Assertion macros for the gyro integrator top level.
`ifndef GYRO_BIAS_CALIBRATED_INTEGRATOR_UNIT_MACROS_SVH
`define GYRO_BIAS_CALIBRATED_INTEGRATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBCI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBCI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/gbci_pkg.sv
// Types, constants and codes shared by the gyro integrator modules.
package gbci_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int AXES            = 3;
   localparam int AXIS_W          = 2;
   localparam int ANGLE_W         = 32;
   localparam int TIME_W          = 16;
   localparam int CSR_DATA_W      = 16;
   localparam int CMD_W           = 2;
   localparam int PROD_W          = 2 * ANGLE_W;
   localparam int DIV_W           = 20;
   localparam int DIV_DIGIT_BITS  = 4;
   localparam int DIV_STEPS       = PROD_W / DIV_DIGIT_BITS;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

   localparam logic [DIV_W-1:0]      RATE_DIVISOR      = 20'd1000000;
   localparam logic [CSR_DATA_W-1:0] RATE_SCALE_RESET  = 16'd1;
   localparam logic [CSR_DATA_W-1:0] CAL_SAMPLES_RESET = 16'd1000;

   typedef enum logic [CMD_W-1:0] {
      OP_INTEGRATE  = 2'd0,
      OP_START_CAL  = 2'd1,
      OP_ACCUM      = 2'd2,
      OP_FINISH_CAL = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_RATE_SCALE  = 1'b0,
      CSR_CAL_SAMPLES = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACCUM,
      ST_FACTOR,
      ST_OPERAND,
      ST_DIVIDEND,
      ST_DIVIDE,
      ST_STORE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              capture;
      logic              clear_all;
      logic              accumulate;
      logic              load_factor;
      logic              load_operand;
      logic              load_dividend;
      logic              div_step;
      logic              store_axis;
      logic              load_out;
      logic              finish;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

endpackage

### hdl/gbci_ctrl.sv
// Sequencer for the gyro integrator: walks axes and divider steps per word.
module gbci_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  gbci_pkg::op_type req_op,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output gbci_pkg::cmd_type cmd
);
   import gbci_pkg::*;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [AXIS_W-1:0]      axis_ff, axis_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_INTEGRATE;
         axis_ff      <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         axis_ff      <= axis_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      axis_in      = axis_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.finish   = (op_ff == OP_FINISH_CAL);
      cmd.axis     = axis_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_op;
               axis_in     = '0;
               case (req_op)
                  OP_START_CAL:  state_in = ST_CLEAR;
                  OP_ACCUM:      state_in = ST_ACCUM;
                  OP_INTEGRATE:  state_in = ST_FACTOR;
                  OP_FINISH_CAL: state_in = ST_OPERAND;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_FACTOR: begin
            cmd.load_factor = 1'b1;
            state_in        = ST_OPERAND;
         end
         ST_OPERAND: begin
            cmd.load_operand = 1'b1;
            state_in         = ST_DIVIDEND;
         end
         ST_DIVIDEND: begin
            cmd.load_dividend = 1'b1;
            div_cnt_in        = '0;
            state_in          = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_axis = 1'b1;
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               state_in = ST_EMIT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_OPERAND;
            end
         end
         ST_EMIT: begin
            // hold until the output register has room
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hdl/gbci_dp.sv
// Datapath of the gyro integrator: state, shared multiplier, radix-16 divider.
module gbci_dp #(
   parameter int SAMPLE_BITS = gbci_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  gbci_pkg::cmd_type                          cmd,
   input  logic                                       csr_write,
   input  gbci_pkg::csr_index_type                    csr_index,
   input  logic [gbci_pkg::CSR_DATA_W-1:0]            csr_data,
   input  logic [SAMPLE_BITS-1:0]                     gyro_x,
   input  logic [SAMPLE_BITS-1:0]                     gyro_y,
   input  logic [SAMPLE_BITS-1:0]                     gyro_z,
   input  logic [gbci_pkg::TIME_W-1:0]                elapsed_time,
   output logic [gbci_pkg::AXES-1:0][gbci_pkg::ANGLE_W-1:0] step_out,
   output logic [gbci_pkg::AXES-1:0][gbci_pkg::ANGLE_W-1:0] heading_out
);
   import gbci_pkg::*;

   logic [CSR_DATA_W-1:0]  rate_scale_ff, rate_scale_in;
   logic [CSR_DATA_W-1:0]  cal_samples_ff, cal_samples_in;
   logic [SAMPLE_BITS-1:0] gyro_ff [AXES];
   logic [SAMPLE_BITS-1:0] gyro_in [AXES];
   logic [TIME_W-1:0]      dt_ff, dt_in;
   logic [ANGLE_W-1:0]     factor_ff, factor_in;
   logic [ANGLE_W-1:0]     mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [PROD_W-1:0]      dvd_ff, dvd_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [ANGLE_W-1:0]     bias_ff [AXES];
   logic [ANGLE_W-1:0]     bias_in [AXES];
   logic [ANGLE_W-1:0]     angle_ff [AXES];
   logic [ANGLE_W-1:0]     angle_in [AXES];
   logic [ANGLE_W-1:0]     step_ff [AXES];
   logic [ANGLE_W-1:0]     step_in [AXES];
   logic [AXES-1:0][ANGLE_W-1:0] step_out_ff, step_out_in;
   logic [AXES-1:0][ANGLE_W-1:0] heading_out_ff, heading_out_in;

   logic [SAMPLE_BITS-1:0] rnd [AXES];
   logic [SAMPLE_BITS-1:0] half [AXES];
   logic [ANGLE_W-1:0]     half_ext [AXES];
   logic [ANGLE_W-1:0]     sel_half, sel_bias;
   logic [ANGLE_W:0]       diff, op_src, op_abs;
   logic [PROD_W-1:0]      product;
   logic [DIV_W-1:0]       divisor;
   logic [CSR_DATA_W-1:0]  cal_div;
   logic [ANGLE_W-1:0]     step_val, bias_val, q_low;
   logic                   q_over;
   logic [DIV_W:0]         rem_t;
   logic [DIV_W-1:0]       rem_w;
   logic [PROD_W-1:0]      dvd_w;

   assign step_out    = step_out_ff;
   assign heading_out = heading_out_ff;

   // halve each sample, rounding toward zero
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         rnd[a]      = gyro_ff[a] + {{(SAMPLE_BITS-1){1'b0}}, gyro_ff[a][SAMPLE_BITS-1]};
         half[a]     = {rnd[a][SAMPLE_BITS-1], rnd[a][SAMPLE_BITS-1:1]};
         half_ext[a] = {{(ANGLE_W-SAMPLE_BITS){half[a][SAMPLE_BITS-1]}}, half[a]};
      end
   end

   assign sel_half = half_ext[cmd.axis];
   assign sel_bias = bias_ff[cmd.axis];
   assign diff     = {sel_half[ANGLE_W-1], sel_half} - {sel_bias[ANGLE_W-1], sel_bias};
   assign op_src   = cmd.finish ? {sel_bias[ANGLE_W-1], sel_bias} : diff;
   assign op_abs   = op_src[ANGLE_W] ? ((ANGLE_W+1)'(0) - op_src) : op_src;
   assign product  = PROD_W'(mag_ff) * PROD_W'(factor_ff);
   assign cal_div  = (cal_samples_ff == '0) ? CSR_DATA_W'(1) : cal_samples_ff;
   assign divisor  = cmd.finish ? {{(DIV_W-CSR_DATA_W){1'b0}}, cal_div} : RATE_DIVISOR;

   // quotient sits in dvd_ff once the divider has run
   assign q_over   = |dvd_ff[PROD_W-1:ANGLE_W-1];
   assign q_low    = dvd_ff[ANGLE_W-1:0];
   always_comb begin
      if (!neg_ff) begin
         step_val = q_over ? {1'b0, {(ANGLE_W-1){1'b1}}} : q_low;
      end else begin
         step_val = q_over ? {1'b1, {(ANGLE_W-1){1'b0}}} : (ANGLE_W'(0) - q_low);
      end
      bias_val = neg_ff ? (ANGLE_W'(0) - q_low) : q_low;
   end

   always_comb begin
      rate_scale_in  = rate_scale_ff;
      cal_samples_in = cal_samples_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RATE_SCALE:  rate_scale_in  = csr_data;
            CSR_CAL_SAMPLES: cal_samples_in = csr_data;
            default:         rate_scale_in  = rate_scale_ff;
         endcase
      end
   end

   always_comb begin
      rem_w = rem_ff;
      dvd_w = dvd_ff;
      rem_t = '0;
      for (int k = 0; k < DIV_DIGIT_BITS; k++) begin
         rem_t = {rem_w, dvd_w[PROD_W-1]};
         if (rem_t >= {1'b0, divisor}) begin
            rem_w = DIV_W'(rem_t - {1'b0, divisor});
            dvd_w = {dvd_w[PROD_W-2:0], 1'b1};
         end else begin
            rem_w = rem_t[DIV_W-1:0];
            dvd_w = {dvd_w[PROD_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      gyro_in[0] = cmd.capture ? gyro_x : gyro_ff[0];
      gyro_in[1] = cmd.capture ? gyro_y : gyro_ff[1];
      gyro_in[2] = cmd.capture ? gyro_z : gyro_ff[2];
      dt_in      = cmd.capture ? elapsed_time : dt_ff;
      factor_in  = cmd.load_factor ? (ANGLE_W'(dt_ff) * ANGLE_W'(rate_scale_ff)) : factor_ff;
      mag_in     = cmd.load_operand ? op_abs[ANGLE_W-1:0] : mag_ff;
      neg_in     = cmd.load_operand ? op_src[ANGLE_W] : neg_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      if (cmd.load_dividend) begin
         dvd_in = cmd.finish ? {{(PROD_W-ANGLE_W){1'b0}}, mag_ff} : product;
         rem_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = dvd_w;
         rem_in = rem_w;
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         bias_in[a]  = bias_ff[a];
         angle_in[a] = angle_ff[a];
         step_in[a]  = step_ff[a];
         if (cmd.clear_all) begin
            bias_in[a]  = '0;
            angle_in[a] = '0;
            step_in[a]  = '0;
         end else if (cmd.accumulate) begin
            bias_in[a] = bias_ff[a] + half_ext[a];
         end else if (cmd.store_axis && (cmd.axis == AXIS_W'(a))) begin
            if (cmd.finish) begin
               bias_in[a] = bias_val;
            end else begin
               step_in[a]  = step_val;
               angle_in[a] = angle_ff[a] + step_val;
            end
         end
      end
   end

   always_comb begin
      step_out_in    = step_out_ff;
      heading_out_in = heading_out_ff;
      if (cmd.load_out) begin
         for (int a = 0; a < AXES; a++) begin
            step_out_in[a]    = step_ff[a];
            heading_out_in[a] = angle_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_scale_ff  <= RATE_SCALE_RESET;
         cal_samples_ff <= CAL_SAMPLES_RESET;
         for (int a = 0; a < AXES; a++) begin
            bias_ff[a]  <= '0;
            angle_ff[a] <= '0;
            step_ff[a]  <= '0;
         end
      end else begin
         rate_scale_ff  <= rate_scale_in;
         cal_samples_ff <= cal_samples_in;
         for (int a = 0; a < AXES; a++) begin
            bias_ff[a]  <= bias_in[a];
            angle_ff[a] <= angle_in[a];
            step_ff[a]  <= step_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         gyro_ff[a] <= gyro_in[a];
      end
      dt_ff          <= dt_in;
      factor_ff      <= factor_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      step_out_ff    <= step_out_in;
      heading_out_ff <= heading_out_in;
   end

endmodule

### hdl/gyro_bias_calibrated_integrator_unit.sv
// Top level of the gyro rate integrator with bias calibration.
// One request word is taken at a time. Start calibration and accumulate
// pass through ST_CLEAR or ST_ACCUM to ST_EMIT. Integrate first forms the
// time-scale factor in ST_FACTOR; integrate and finish calibration then run
// ST_OPERAND, ST_DIVIDEND, ST_DIVIDE and ST_STORE for each of the three
// axes in turn, ST_DIVIDEND loading the product for integrate. The divider
// is shared by the axes and retires four quotient bits a cycle over a
// 64-bit dividend. ST_EMIT loads the result word once the output register
// has room and returns to idle, where the next request is taken. A new
// request is accepted while the previous result still waits on rsp_tready.
// Configuration writes are always ready and must only be issued while idle.
`include "gyro_bias_calibrated_integrator_unit_macros.svh"

module gyro_bias_calibrated_integrator_unit #(
   parameter int SAMPLE_BITS = gbci_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_DATA_W = ((3 * SAMPLE_BITS + gbci_pkg::TIME_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = 6 * gbci_pkg::ANGLE_W
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // gyro_x, gyro_y, gyro_z, elapsed_time, zero pad
   input  logic [REQ_DATA_W-1:0]            req_tdata,
   // command
   input  logic [gbci_pkg::CMD_W-1:0]       req_tuser,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // step_x, step_y, step_z, heading_x, heading_y, heading_z
   output logic [RSP_DATA_W-1:0]            rsp_tdata,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  gbci_pkg::csr_index_type          csr_index,
   input  logic [gbci_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gbci_pkg::*;

   cmd_type                      cmd;
   logic [AXES-1:0][ANGLE_W-1:0] step_out;
   logic [AXES-1:0][ANGLE_W-1:0] heading_out;
   logic [8:0]                   cmd_bits;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {heading_out, step_out};

   gbci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (op_type'(req_tuser)),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .cmd       (cmd)
   );

   gbci_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .gyro_x       (req_tdata[SAMPLE_BITS-1:0]),
      .gyro_y       (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .gyro_z       (req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .elapsed_time (req_tdata[3*SAMPLE_BITS+TIME_W-1:3*SAMPLE_BITS]),
      .step_out     (step_out),
      .heading_out  (heading_out)
   );

   assign cmd_bits = {cmd.capture, cmd.clear_all, cmd.accumulate, cmd.load_factor,
                      cmd.load_operand, cmd.load_dividend, cmd.div_step,
                      cmd.store_axis, cmd.load_out};

   `GBCI_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `GBCI_ASSERT_SAME(a_no_overwrite, cmd.load_out, !rsp_tvalid || rsp_tready, "result overwritten")
   `GBCI_ASSERT_SAME(a_single_cmd, 1'b1, $onehot0(cmd_bits), "several datapath commands")
   `GBCI_ASSERT_NEXT(a_div_runs, cmd.div_step, cmd.div_step || cmd.store_axis, "divider cut short")

endmodule

### verif/gyro_bias_calibrated_integrator_unit_tb.sv
// Self-checking testbench for the gyro rate integrator: calibration, bias and angle checks.
module gyro_bias_calibrated_integrator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gbci_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_AT      = 1100;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 70;

   typedef struct packed {
      op_type            cmd;
      logic [15:0]       dt;
      logic [2:0][15:0]  g;    // g[0] is the x axis
   } gyro_word_t;

   typedef struct packed {
      logic [2:0][31:0]  heading;
      logic [2:0][31:0]  step;  // step[0] sits in the lowest bits of rsp_tdata
   } angle_result_t;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [CMD_W-1:0] req_tuser = '0;

   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;

   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_RATE_SCALE;
   logic [15:0]   csr_data  = '0;

   // predictor state
   logic [15:0] scale_reg     = RATE_SCALE_RESET;
   logic [15:0] cal_count_reg = CAL_SAMPLES_RESET;
   logic [31:0] bias_sum  [3] = '{default: '0};
   logic [31:0] angle_acc [3] = '{default: '0};
   logic [31:0] last_inc  [3] = '{default: '0};

   gyro_word_t    sample_queue [$];
   angle_result_t angle_queue  [$];
   gyro_word_t    word_on_bus;

   int queued_total   = 0;
   int accepted_total = 0;
   int results_seen   = 0;
   int fails          = 0;
   int cycles         = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   gyro_bias_calibrated_integrator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] scaled_step(longint half, logic [31:0] bias,
                                               logic [15:0] dt);
      longint      diff;
      logic [63:0] mag;
      logic [63:0] factor;
      logic [63:0] q;
      diff   = half - longint'($signed(bias));
      mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
      factor = 64'(dt) * 64'(scale_reg);
      q      = (mag * factor) / 64'd1000000;
      // clamp to the signed 32-bit range
      if (diff >= 0)
         return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q >= 64'h8000_0000)
         return 32'h8000_0000;
      return 32'd0 - q[31:0];
   endfunction

   function automatic angle_result_t predict_angles(gyro_word_t w);
      angle_result_t r;
      longint        h;
      longint        n;
      longint        q;
      for (int a = 0; a < 3; a++) begin
         h = longint'($signed(w.g[a])) / 2;
         case (w.cmd)
            OP_INTEGRATE: begin
               last_inc[a]  = scaled_step(h, bias_sum[a], w.dt);
               angle_acc[a] = angle_acc[a] + last_inc[a];
            end
            OP_START_CAL: begin
               bias_sum[a]  = '0;
               angle_acc[a] = '0;
               last_inc[a]  = '0;
            end
            OP_ACCUM: begin
               bias_sum[a] = bias_sum[a] + h[31:0];
            end
            default: begin
               // a zero count divides by one
               n = (cal_count_reg == 16'd0) ? 64'sd1 : longint'(cal_count_reg);
               q = longint'($signed(bias_sum[a])) / n;
               bias_sum[a] = q[31:0];
            end
         endcase
         r.step[a]    = last_inc[a];
         r.heading[a] = angle_acc[a];
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            angle_queue.push_back(predict_angles(word_on_bus));
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               word_on_bus = sample_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {word_on_bus.dt, word_on_bus.g};
               req_tuser  <= word_on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      angle_result_t got;
      angle_result_t want;
      logic          ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (angle_queue.size() == 0) begin
               $display("%0t: result word with none expected: %h", $time, rsp_tdata);
               fails++;
            end else begin
               want = angle_queue.pop_front();
               for (int a = 0; a < 3; a++) begin
                  if (got.step[a] !== want.step[a]) begin
                     $display("%0t: step axis %0d expected %h got %h",
                              $time, a, want.step[a], got.step[a]);
                     fails++;
                  end
                  if (got.heading[a] !== want.heading[a]) begin
                     $display("%0t: heading axis %0d expected %h got %h",
                              $time, a, want.heading[a], got.heading[a]);
                     fails++;
                  end
               end
            end
         end
         // hold the output off for a long stretch once, so the block backs up
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = ($urandom_range(0, 99) >= recv_idle_pct);
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_word(op_type c, int x, int y, int z, int dt);
      gyro_word_t w;
      w.cmd  = c;
      w.g[0] = 16'(x);
      w.g[1] = 16'(y);
      w.g[2] = 16'(z);
      w.dt   = 16'(dt);
      sample_queue.push_back(w);
      queued_total++;
   endtask

   task automatic set_csr(csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RATE_SCALE)
         scale_reg = val;
      else
         cal_count_reg = val;
   endtask

   task automatic drain();
      while (accepted_total != queued_total || angle_queue.size() != 0)
         @(posedge clock);
   endtask

   function automatic int rnd16();
      return $urandom_range(0, 65535);
   endfunction

   function automatic int jitter();
      return $urandom_range(0, 200) - 100;
   endfunction

   function automatic int rnd_dt();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return 0;
      if (pick == 1)
         return 65535;
      if (pick < 5)
         return $urandom_range(1, 200);
      return rnd16();
   endfunction

   task automatic run_random(int n);
      int stop_at;
      int pick;
      int base [3];
      stop_at = queued_total + n;
      while (queued_total < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // calibrate around a random offset, then integrate, mostly near it
            queue_word(OP_START_CAL, rnd16(), rnd16(), rnd16(), rnd16());
            for (int a = 0; a < 3; a++)
               base[a] = $urandom_range(0, 4000) - 2000;
            repeat ($urandom_range(1, 24))
               queue_word(OP_ACCUM, base[0] + jitter(), base[1] + jitter(),
                          base[2] + jitter(), rnd16());
            queue_word(OP_FINISH_CAL, rnd16(), rnd16(), rnd16(), rnd16());
            repeat ($urandom_range(1, 16)) begin
               if ($urandom_range(0, 3) == 0)
                  queue_word(OP_INTEGRATE, rnd16(), rnd16(), rnd16(), rnd_dt());
               else
                  queue_word(OP_INTEGRATE, base[0] + jitter(), base[1] + jitter(),
                             base[2] + jitter(), rnd_dt());
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 12))
               queue_word(OP_INTEGRATE, rnd16(), rnd16(), rnd16(), rnd_dt());
         end else begin
            repeat ($urandom_range(1, 6))
               queue_word(op_type'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16(),
                          rnd16());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 67;

      // reset settings, extreme samples, odd values that truncate
      queue_word(OP_INTEGRATE, 32767, -32768, -1, 65535);
      queue_word(OP_INTEGRATE, 1, -1, 0, 0);
      queue_word(OP_INTEGRATE, -3, 3, 2, 1000);
      drain();
      set_csr(CSR_RATE_SCALE, 16'hFFFF);
      set_csr(CSR_CAL_SAMPLES, 16'd3);

      queue_word(OP_START_CAL, 16'h5A5A, 16'hA5A5, 16'hFFFF, 16'h1234);
      queue_word(OP_ACCUM, 32767, -32768, -1, 0);
      queue_word(OP_ACCUM, -32767, 100, 1, 65535);
      queue_word(OP_ACCUM, 5, -5, 7, 9);
      queue_word(OP_FINISH_CAL, 0, 0, 0, 0);
      queue_word(OP_INTEGRATE, 32767, -32768, 0, 65535);
      queue_word(OP_INTEGRATE, 0, 0, 0, 0);
      queue_word(OP_INTEGRATE, -1, 1, -32768, 1);
      // accumulate on top of a finished bias, then integrate against the new sum
      queue_word(OP_ACCUM, 1000, -1000, 0, 0);
      queue_word(OP_INTEGRATE, 0, 0, 0, 500);
      drain();

      // zero count leaves the sums as the bias
      set_csr(CSR_CAL_SAMPLES, 16'd0);
      queue_word(OP_START_CAL, 0, 0, 0, 0);
      queue_word(OP_ACCUM, 200, -200, 77, 0);
      queue_word(OP_ACCUM, 3, 3, 3, 0);
      queue_word(OP_FINISH_CAL, 0, 0, 0, 0);
      queue_word(OP_INTEGRATE, 1000, 1000, 1000, 65535);

      // unfinished sums drive the step past both 32-bit bounds; headings wrap
      queue_word(OP_START_CAL, 0, 0, 0, 0);
      repeat (40) queue_word(OP_ACCUM, -32768, 32767, 1, 0);
      repeat (3) queue_word(OP_INTEGRATE, 32767, -32768, 0, 65535);
      drain();

      set_csr(CSR_RATE_SCALE, 16'($urandom_range(1, 65535)));
      set_csr(CSR_CAL_SAMPLES, 16'($urandom_range(1, 40)));
      run_random(360);
      drain();

      send_idle_pct = 67;
      recv_idle_pct = 8;
      set_csr(CSR_RATE_SCALE, 16'hFFFF);
      set_csr(CSR_CAL_SAMPLES, 16'hFFFF);
      run_random(360);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_csr(CSR_RATE_SCALE, 16'd0);
      set_csr(CSR_CAL_SAMPLES, 16'd1);
      run_random(360);
      drain();

      set_csr(CSR_RATE_SCALE, 16'(rnd16()));
      set_csr(CSR_CAL_SAMPLES, 16'($urandom_range(1, 65535)));
      run_random(360);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
